// ----- rtl/cfs_pkg.sv -----
// Shared types and constants for the compact field skipper.
// Used by cfs_ctrl, cfs_dpath and compact_field_skipper_core. No dependencies.
package cfs_pkg;

  localparam int MaxDepth = 8;
  localparam int LvlW = $clog2(MaxDepth + 1);
  localparam int IdxW = (MaxDepth > 1) ? $clog2(MaxDepth) : 1;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;
  localparam logic [1:0] KIND_RSVD  = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_UNSUP   = 3'd1;
  localparam logic [2:0] ST_VARINT  = 3'd2;
  localparam logic [2:0] ST_ZDELTA  = 3'd3;
  localparam logic [2:0] ST_WRAP    = 3'd4;
  localparam logic [2:0] ST_ENDED   = 3'd5;
  localparam logic [2:0] ST_DEEP    = 3'd6;

  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_I8    = 4'd1;
  localparam logic [3:0] PH_V32   = 4'd2;
  localparam logic [3:0] PH_V64   = 4'd3;
  localparam logic [3:0] PH_BLEN  = 4'd4;
  localparam logic [3:0] PH_PAY   = 4'd5;
  localparam logic [3:0] PH_LHDR  = 4'd6;
  localparam logic [3:0] PH_LSIZE = 4'd7;
  localparam logic [3:0] PH_SHDR  = 4'd8;
  localparam logic [3:0] PH_DELTA = 4'd9;

  localparam logic [3:0] T_I8 = 4'd3;
  localparam logic [3:0] T_I16 = 4'd4;
  localparam logic [3:0] T_I32 = 4'd5;
  localparam logic [3:0] T_I64 = 4'd6;
  localparam logic [3:0] T_BIN = 4'd8;
  localparam logic [3:0] T_LIST = 4'd9;
  localparam logic [3:0] T_STRUCT = 4'd12;

  // controller -> datapath commands
  typedef struct packed {
    logic       clear;     // start: reset counters
    logic       count;     // data byte: bump byte total
    logic       work;      // data byte: run one parse step
    logic       adv;       // pop / continue step after a finished value
    logic       stop;      // end of buffer: drop the parse
  } cfs_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic       done;      // parse finished this step
    logic       more;      // another advance step is needed
    logic [2:0] st;
  } cfs_stat_t;

  function automatic logic type_ok(input logic [3:0] t);
    return t == T_I8 || t == T_I16 || t == T_I32 || t == T_I64 ||
           t == T_BIN || t == T_LIST || t == T_STRUCT;
  endfunction

endpackage

// ----- rtl/compact_field_skipper_core.sv -----
// Top level of the compact field skipper: walks one compact-protocol value.
// Depends on cfs_pkg, cfs_ctrl and cfs_dpath.
// Results: an error found on a byte shows on out_valid the cycle after that byte is
//   taken; a finished value first goes through the advance state, which pops lists.
// Throughput: one word per cycle while no advance is due or result waits on out_stall;
//   a finished leaf or closed struct stalls the input through the advance state.
// Reset: synchronous rst returns to idle with an empty stack and no result pending.
module compact_field_skipper_core import cfs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [3:0]  start_type,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [31:0] consumed
);

  cfs_cmd_t  cmd;
  cfs_stat_t stat;
  logic      idle;
  logic [31:0] total;

  // sequence the handshake and the advance loop
  cfs_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .consumed(consumed),
    .cmd(cmd), .stat(stat), .idle(idle), .total(total)
  );

  // parse state, frame stack and byte counter
  cfs_dpath u_dpath (
    .clk(clk), .rst(rst), .cmd(cmd),
    .start_type(start_type), .data_byte(data_byte),
    .stat(stat), .idle(idle), .total(total)
  );

endmodule

// ----- rtl/cfs_dpath.sv -----
// Datapath of the compact field skipper: phase, frame stack, varint, counters.
// Depends on cfs_pkg; driven by cfs_ctrl.
module cfs_dpath import cfs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfs_cmd_t   cmd,
  input  logic [3:0] start_type,
  input  logic [7:0] data_byte,
  output cfs_stat_t  stat,
  output logic       idle,
  output logic [31:0] total
);

  logic [3:0]  phase, phase_next;
  logic [LvlW-1:0] level, level_next;
  logic [3:0]  pending, pending_next;
  logic [3:0]  vbytes, vbytes_next;
  logic [31:0] vvalue, vvalue_next;
  logic [31:0] payload, payload_next;
  logic [31:0] byte_total, byte_total_next;

  logic        f_list [MaxDepth];
  logic [3:0]  f_elem [MaxDepth];
  logic [31:0] f_rem  [MaxDepth];
  logic [15:0] f_id   [MaxDepth];

  logic        wr_open, wr_elem, wr_rem, wr_id;
  logic [IdxW-1:0] wr_idx;
  logic        open_list;
  logic [3:0]  elem_val;
  logic [31:0] rem_val;
  logic [15:0] id_val;

  logic [IdxW-1:0] top;
  logic [3:0]  nib_lo, nib_hi;
  logic [3:0]  vn;
  logic [31:0] vacc;
  logic        vbad, vmore;
  logic [15:0] id_sum;

  assign top = (level == '0) ? '0 : IdxW'(level - 1'b1);
  assign idle = phase == PH_IDLE;
  assign total = byte_total_next;
  assign nib_lo = data_byte[3:0];
  assign nib_hi = data_byte[7:4];

  always_comb begin
    logic [3:0] bt;
    logic       bg;
    logic       st_err;
    logic [15:0] d;
    phase_next = phase;
    level_next = level;
    pending_next = pending;
    vbytes_next = vbytes;
    vvalue_next = vvalue;
    payload_next = payload;
    byte_total_next = byte_total;
    wr_open = 1'b0; wr_elem = 1'b0; wr_rem = 1'b0; wr_id = 1'b0;
    wr_idx = top; open_list = 1'b0;
    elem_val = nib_lo; rem_val = '0; id_val = '0;
    stat = '0;
    bt = '0; bg = 1'b0; st_err = 1'b0; d = '0;
    vn = vbytes + 4'd1;
    vacc = vvalue;
    unique case (vbytes)
      4'd0: vacc = vvalue | {25'd0, data_byte[6:0]};
      4'd1: vacc = vvalue | {18'd0, data_byte[6:0], 7'd0};
      4'd2: vacc = vvalue | {11'd0, data_byte[6:0], 14'd0};
      4'd3: vacc = vvalue | {4'd0, data_byte[6:0], 21'd0};
      4'd4: vacc = vvalue | {data_byte[3:0], 28'd0};
      default: vacc = vvalue;
    endcase
    if (phase == PH_V64) begin
      vbad  = (vn >= 4'd10) && ((data_byte & 8'hfe) != 8'd0);
      vmore = (vn < 4'd10) && data_byte[7];
    end else begin
      vbad  = (vn >= 4'd5) && ((data_byte & 8'hf0) != 8'd0);
      vmore = (vn < 4'd5) && data_byte[7];
    end
    id_sum = f_id[top] + d;

    if (cmd.clear) begin
      level_next = '0;
      byte_total_next = '0;
      payload_next = '0;
      bt = start_type; bg = 1'b1;
    end else if (cmd.count && byte_total != 32'hffffffff) begin
      byte_total_next = byte_total + 32'd1;
    end

    if (cmd.work) begin
      unique case (phase)
        PH_I8: stat.more = 1'b1;
        PH_V32, PH_BLEN, PH_LSIZE, PH_DELTA, PH_V64: begin
          vbytes_next = vn;
          if (phase != PH_V64) vvalue_next = vacc;
          if (vbad) begin
            stat.done = 1'b1; stat.st = ST_VARINT;
          end else if (!vmore) begin
            unique case (phase)
              PH_BLEN: begin
                if (vacc == '0) stat.more = 1'b1;
                else begin payload_next = vacc; phase_next = PH_PAY; end
              end
              PH_LSIZE: begin
                wr_rem = 1'b1; rem_val = vacc;
                if (!type_ok(f_elem[top])) begin
                  stat.done = 1'b1; stat.st = ST_UNSUP;
                end else stat.more = 1'b1;
              end
              PH_DELTA: begin
                d = vacc[15:0];
                id_sum = f_id[top] + d;
                st_err = 1'b1;
                bt = pending;
              end
              default: stat.more = 1'b1;
            endcase
          end
        end
        PH_PAY: begin
          if (payload > 32'd1) payload_next = payload - 32'd1;
          else begin payload_next = '0; stat.more = 1'b1; end
        end
        PH_LHDR: begin
          wr_elem = 1'b1; elem_val = nib_lo;
          if (nib_hi == 4'hf) begin
            vbytes_next = '0; vvalue_next = '0; phase_next = PH_LSIZE;
          end else begin
            wr_rem = 1'b1; rem_val = {28'd0, nib_hi};
            if (!type_ok(nib_lo)) begin
              stat.done = 1'b1; stat.st = ST_UNSUP;
            end else stat.more = 1'b1;
          end
        end
        PH_SHDR: begin
          if (nib_lo == 4'd0) begin
            if (level != '0) level_next = level - 1'b1;
            stat.more = 1'b1;
          end else if (nib_hi == 4'd0) begin
            pending_next = nib_lo;
            vbytes_next = '0; vvalue_next = '0; phase_next = PH_DELTA;
          end else begin
            d = {12'd0, nib_hi};
            id_sum = f_id[top] + d;
            st_err = 1'b1;
            bt = nib_lo;
          end
        end
        default: begin stat.done = 1'b1; stat.st = ST_UNSUP; end
      endcase
      if (st_err) begin
        if (d == '0) begin stat.done = 1'b1; stat.st = ST_ZDELTA; end
        else begin
          wr_id = 1'b1; id_val = id_sum;
          if (id_sum == '0) begin stat.done = 1'b1; stat.st = ST_WRAP; end
          else bg = 1'b1;
        end
      end
    end

    if (cmd.adv) begin
      if (level == '0) begin
        stat.done = 1'b1; stat.st = ST_OK;
      end else if (f_list[top]) begin
        if (f_rem[top] == '0) begin
          level_next = level - 1'b1; stat.more = 1'b1;
        end else begin
          wr_rem = 1'b1; rem_val = f_rem[top] - 32'd1;
          bt = f_elem[top]; bg = 1'b1;
        end
      end else phase_next = PH_SHDR;
    end

    if (bg) begin
      vbytes_next = '0; vvalue_next = '0;
      unique case (bt)
        T_I8: phase_next = PH_I8;
        T_I16, T_I32: phase_next = PH_V32;
        T_I64: phase_next = PH_V64;
        T_BIN: phase_next = PH_BLEN;
        T_LIST, T_STRUCT: begin
          if (32'(level_next) >= 32'(MaxDepth)) begin
            stat.done = 1'b1; stat.st = ST_DEEP;
          end else begin
            wr_open = 1'b1; wr_idx = IdxW'(level_next);
            open_list = bt == T_LIST;
            level_next = level_next + 1'b1;
            phase_next = (bt == T_LIST) ? PH_LHDR : PH_SHDR;
          end
        end
        default: begin stat.done = 1'b1; stat.st = ST_UNSUP; end
      endcase
    end

    if (cmd.stop) begin
      stat.done = 1'b1; stat.st = ST_ENDED;
    end

    if (stat.done) begin
      stat.more = 1'b0;
      phase_next = PH_IDLE; level_next = '0;
      vbytes_next = '0; vvalue_next = '0; payload_next = '0;
    end
  end

  // an opened frame sits above the current top whenever a top write lands too
  always_ff @(posedge clk) begin
    if (wr_elem) f_elem[top] <= elem_val;
    if (wr_rem) f_rem[top] <= rem_val;
    if (wr_id) f_id[top] <= id_val;
    if (wr_open) begin
      f_list[wr_idx] <= open_list;
      f_elem[wr_idx] <= '0;
      f_rem[wr_idx] <= '0;
      f_id[wr_idx] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      level <= '0;
      pending <= '0;
      vbytes <= '0;
      vvalue <= '0;
      payload <= '0;
      byte_total <= '0;
    end else begin
      phase <= phase_next;
      level <= level_next;
      pending <= pending_next;
      vbytes <= vbytes_next;
      vvalue <= vvalue_next;
      payload <= payload_next;
      byte_total <= byte_total_next;
    end
  end

`ifndef SYNTH
  a_depth: assert property (@(posedge clk) disable iff (rst)
    32'(level) <= 32'(MaxDepth)) else $error("stack level past depth");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    stat.done |=> idle) else $error("not idle after result");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(stat.done && stat.more)) else $error("done and more together");
`endif

endmodule

// ----- rtl/cfs_ctrl.sv -----
// Controller of the compact field skipper: handshakes, advance loop, result register.
// Depends on cfs_pkg; drives cfs_dpath.
module cfs_ctrl import cfs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] kind,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] status,
  output logic [31:0] consumed,
  output cfs_cmd_t   cmd,
  input  cfs_stat_t  stat,
  input  logic       idle,
  input  logic [31:0] total
);

  localparam logic [0:0] S_TAKE = 1'b0;
  localparam logic [0:0] S_ADV  = 1'b1;

  logic [0:0] state, state_next;
  logic       hold, take, fire;
  logic       ov, ov_next;
  logic [2:0] rst_st;
  logic [31:0] rcount;

  // only a taken word waits for a free output register; advance results do not wait
  assign hold = ov && out_stall;
  assign in_stall = (state != S_TAKE) || hold;
  assign take = in_valid && !in_stall;
  assign out_valid = ov;
  assign status = rst_st;
  assign consumed = rcount;

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_TAKE: if (take) begin
        unique case (kind)
          KIND_START: cmd.clear = 1'b1;
          KIND_DATA: if (!idle) begin cmd.count = 1'b1; cmd.work = 1'b1; end
          KIND_END: if (!idle) cmd.stop = 1'b1;
          default: ;
        endcase
      end
      S_ADV: cmd.adv = 1'b1;
      default: ;
    endcase
    fire = stat.done;
    if (stat.more) state_next = S_ADV;
    else if (state == S_ADV) state_next = S_TAKE;
    ov_next = (ov && out_stall) || fire;
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rst_st <= stat.st;
      rcount <= total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_TAKE;
      ov <= 1'b0;
    end else begin
      state <= state_next;
      ov <= ov_next;
    end
  end

`ifndef SYNTH
  a_no_take_adv: assert property (@(posedge clk) disable iff (rst)
    state == S_ADV |-> !take) else $error("input taken mid advance");
  a_no_over: assert property (@(posedge clk) disable iff (rst)
    hold |-> !fire) else $error("result overwrote pending word");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    hold |=> ov) else $error("pending result lost");
`endif

endmodule

// ----- sim/compact_field_skipper_core_tb.sv -----
// Testbench for compact_field_skipper_core: drives start, byte and end words and
// checks every result word against a built-in predictor of the skip walk.
// Depends on cfs_pkg and the RTL of compact_field_skipper_core.
module compact_field_skipper_core_tb;
  import cfs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ADV_DONE = 8;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] consumed;
  } skip_result_t;

  // Scoreboard: holds the skip predictor's state and the queue of expected words.
  class skip_scoreboard;
    logic [3:0]  phase;
    int unsigned level;
    logic        fr_list[MaxDepth];
    logic [3:0]  fr_elem[MaxDepth];
    logic [31:0] fr_left[MaxDepth];
    logic [15:0] fr_id[MaxDepth];
    logic [3:0]  pend_type;
    int unsigned vbytes;
    logic [31:0] vvalue;
    logic [31:0] pay_left;
    logic [31:0] total;
    skip_result_t pending_q[$];
    int mismatches;
    int checked;

    function void clear();
      phase = PH_IDLE; level = 0; pend_type = 0; vbytes = 0; vvalue = 0;
      pay_left = 0; total = 0; mismatches = 0; checked = 0;
      for (int k = 0; k < MaxDepth; k++) begin
        fr_list[k] = 0; fr_elem[k] = 0; fr_left[k] = 0; fr_id[k] = 0;
      end
    endfunction

    function int unsigned top();
      int unsigned t;
      t = (level != 0) ? level - 1 : 0;
      return (t < MaxDepth) ? t : MaxDepth - 1;
    endfunction

    function void finish_word(logic [2:0] st);
      skip_result_t r;
      r.status = st;
      r.consumed = total;
      pending_q.push_back(r);
      phase = PH_IDLE; level = 0; vbytes = 0; vvalue = 0; pay_left = 0;
    endfunction

    // Returns 0 or an error status.
    function int open_value(logic [3:0] t);
      int unsigned k;
      vbytes = 0;
      vvalue = 0;
      case (t)
        T_I8: phase = PH_I8;
        T_I16, T_I32: phase = PH_V32;
        T_I64: phase = PH_V64;
        T_BIN: phase = PH_BLEN;
        T_LIST, T_STRUCT: begin
          if (level >= MaxDepth) return ST_DEEP;
          k = level;
          fr_list[k] = (t == T_LIST);
          fr_elem[k] = 0; fr_left[k] = 0; fr_id[k] = 0;
          level++;
          phase = fr_list[k] ? PH_LHDR : PH_SHDR;
        end
        default: return ST_UNSUP;
      endcase
      return 0;
    endfunction

    // Returns ADV_DONE when the whole value is done, else 0 or an error status.
    function int step_out();
      int unsigned k;
      forever begin
        if (level == 0) return ADV_DONE;
        k = top();
        if (fr_list[k]) begin
          if (fr_left[k] == 0) begin
            level--;
            continue;
          end
          fr_left[k]--;
          return open_value(fr_elem[k]);
        end
        phase = PH_SHDR;
        return 0;
      end
    endfunction

    function int add_field(logic [3:0] t, logic [15:0] d);
      int unsigned k;
      k = top();
      if (d == 0) return ST_ZDELTA;
      fr_id[k] = fr_id[k] + d;
      if (fr_id[k] == 0) return ST_WRAP;
      return open_value(t);
    endfunction

    // -1 bad, 0 more, 1 complete
    function int varint_byte(logic [7:0] b, int unsigned limit);
      vbytes++;
      if (limit == 5 && vbytes <= 5) vvalue |= 32'(b[6:0]) << (7 * (vbytes - 1));
      if (vbytes >= limit) begin
        if (limit == 5) return (b[7:4] != 0) ? -1 : 1;
        return (b[7:1] != 0) ? -1 : 1;
      end
      return b[7] ? 0 : 1;
    endfunction

    // Note one accepted input word and queue the result it causes, if any.
    function void note_word(logic [1:0] kd, logic [3:0] st, logic [7:0] b);
      int r, v;
      int unsigned k;
      if (kd == KIND_START) begin
        level = 0; total = 0; pay_left = 0;
        r = open_value(st);
        if (r != 0) finish_word(3'(r));
        return;
      end
      if (kd == KIND_RSVD || phase == PH_IDLE) return;
      if (kd == KIND_END) begin
        finish_word(ST_ENDED);
        return;
      end
      if (total != 32'hffffffff) total++;
      k = top();
      r = 0;
      case (phase)
        PH_I8: r = step_out();
        PH_V32, PH_BLEN, PH_LSIZE, PH_DELTA: begin
          v = varint_byte(b, 5);
          if (v < 0) begin finish_word(ST_VARINT); return; end
          if (v == 0) return;
          if (phase == PH_V32) r = step_out();
          else if (phase == PH_BLEN) begin
            if (vvalue == 0) r = step_out();
            else begin pay_left = vvalue; phase = PH_PAY; return; end
          end else if (phase == PH_LSIZE) begin
            fr_left[k] = vvalue;
            if (!type_ok(fr_elem[k])) begin finish_word(ST_UNSUP); return; end
            r = step_out();
          end else r = add_field(pend_type, vvalue[15:0]);
        end
        PH_V64: begin
          v = varint_byte(b, 10);
          if (v < 0) begin finish_word(ST_VARINT); return; end
          if (v == 0) return;
          r = step_out();
        end
        PH_PAY: begin
          if (pay_left != 0) pay_left--;
          if (pay_left != 0) return;
          r = step_out();
        end
        PH_LHDR: begin
          fr_elem[k] = b[3:0];
          if (b[7:4] == 4'hf) begin
            vbytes = 0; vvalue = 0; phase = PH_LSIZE;
            return;
          end
          fr_left[k] = 32'(b[7:4]);
          if (!type_ok(fr_elem[k])) begin finish_word(ST_UNSUP); return; end
          r = step_out();
        end
        PH_SHDR: begin
          if (b[3:0] == 0) begin
            if (level != 0) level--;
            r = step_out();
          end else if (b[7:4] == 0) begin
            pend_type = b[3:0]; vbytes = 0; vvalue = 0; phase = PH_DELTA;
            return;
          end else r = add_field(b[3:0], 16'(b[7:4]));
        end
        default: begin finish_word(ST_UNSUP); return; end
      endcase
      if (r == ADV_DONE) finish_word(ST_OK);
      else if (r > 0) finish_word(3'(r));
    endfunction

    function void check_word(logic [2:0] st, logic [31:0] cnt);
      skip_result_t e;
      checked++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: status %0d consumed %0d", st, cnt);
        return;
      end
      e = pending_q.pop_front();
      if (e.status !== st || e.consumed !== cnt) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected status %0d consumed %0d, got status %0d consumed %0d",
                   e.status, e.consumed, st, cnt);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  kind = KIND_START;
  logic [3:0]  start_type = 0;
  logic [7:0]  data_byte = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [2:0]  status;
  logic [31:0] consumed;

  skip_scoreboard sb;
  logic [9:0] word_kind[$];  // kind, start_type and low byte nibble of words still to send
  logic [7:0] byte_q[$];
  int hold_off = 0;          // long receiver stall, counted down in its own process
  bit stim_done = 0;

  compact_field_skipper_core u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .start_type(start_type), .data_byte(data_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .consumed(consumed)
  );

  always #2 clk = ~clk;

  // Queue up one word for the sender.
  task automatic push_word(logic [1:0] kd, logic [3:0] st, logic [7:0] b);
    word_kind.push_back({kd, st, b[3:0]});
    byte_q.push_back(b);
  endtask

  task automatic push_start(logic [3:0] t);
    push_word(KIND_START, t, 8'($urandom));
  endtask

  task automatic push_data(logic [7:0] b);
    push_word(KIND_DATA, 4'($urandom), b);
  endtask

  // Emit a varint of n bytes carrying value v; the last byte has its high bit clear.
  task automatic push_varint(logic [31:0] v, int n);
    for (int k = 0; k < n; k++) begin
      if (k == n - 1) push_data({1'b0, v[6:0]});
      else push_data({1'b1, v[6:0]});
      v = v >> 7;
    end
  endtask

  // Emit a well-formed value of type t with random content, bounded nesting.
  task automatic push_value(logic [3:0] t, int depth);
    int n, len;
    logic [3:0] et, ft;
    logic [3:0] leaf[5];
    leaf = '{T_I8, T_I16, T_I32, T_I64, T_BIN};
    case (t)
      T_I8: push_data(8'($urandom));
      T_I16, T_I32: begin
        n = $urandom_range(1, 5);
        push_varint($urandom & ((n == 5) ? 32'h0fffffff : 32'hffffffff), n);
      end
      T_I64: begin
        n = $urandom_range(1, 10);
        for (int k = 0; k < n - 1; k++) push_data(8'h80 | 8'($urandom));
        push_data((n == 10) ? 8'($urandom_range(0, 1)) : 8'($urandom) & 8'h7f);
      end
      T_BIN: begin
        len = $urandom_range(0, 6);
        push_varint(32'(len), 1);
        for (int k = 0; k < len; k++) push_data(8'($urandom));
      end
      T_LIST: begin
        len = (depth >= 3) ? 0 : $urandom_range(0, 4);
        et = (depth >= 2 || $urandom_range(0, 2) != 0) ? leaf[$urandom_range(0, 4)]
             : (($urandom & 1) ? T_LIST : T_STRUCT);
        if ($urandom_range(0, 4) == 0) begin
          push_data({4'hf, et});
          push_varint(32'(len), $urandom_range(1, 2));
        end else push_data({4'(len), et});
        for (int k = 0; k < len; k++) push_value(et, depth + 1);
      end
      default: begin  // struct
        n = (depth >= 3) ? 0 : $urandom_range(0, 3);
        for (int k = 0; k < n; k++) begin
          ft = (depth >= 2 || $urandom_range(0, 2) != 0) ? leaf[$urandom_range(0, 4)]
               : (($urandom & 1) ? T_LIST : T_STRUCT);
          if ($urandom_range(0, 3) == 0) begin
            push_data({4'h0, ft});
            push_varint(32'($urandom_range(1, 300)), 2);
          end else push_data({4'($urandom_range(1, 15)), ft});
          push_value(ft, depth + 1);
        end
        push_data(8'h00);
      end
    endcase
  endtask

  // Sender: bursts of random length with random gaps; payload holds while stalled.
  initial begin : sender
    int burst;
    logic [9:0] w;
    logic [7:0] b;
    @(negedge clk);
    wait (!rst);
    forever begin
      burst = $urandom_range(1, 30);
      while (burst > 0 && word_kind.size() > 0) begin
        w = word_kind.pop_front();
        b = byte_q.pop_front();
        @(negedge clk);
        in_valid <= 1;
        kind <= w[9:8];
        start_type <= w[7:4];
        data_byte <= b;
        do @(posedge clk); while (in_stall);
        sb.note_word(w[9:8], w[7:4], b);
        burst--;
      end
      @(negedge clk);
      in_valid <= 0;
      if (stim_done && word_kind.size() == 0) break;
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
  end

  // Receiver: its own stall pattern, plus one long hold-off on request.
  initial begin : receiver
    int mode;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_stall <= 1;
        hold_off--;
      end else begin
        mode = ($time / 2000) % 3;
        out_stall <= (mode == 0) ? 1'b0 : ($urandom_range(0, 3) == 0);
      end
    end
  end

  // Check every accepted result word.
  always @(posedge clk)
    if (!rst && out_valid && !out_stall) sb.check_word(status, consumed);

  initial begin : limit
    #4ms;
    $display("status: fail");
    $finish;
  end

  initial begin : main
    logic [3:0] tt;
    int waited;
    sb = new();
    sb.clear();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: every start type, then the named corner cases.
    for (int t = 0; t < 16; t++) begin
      push_start(4'(t));
      push_value(4'(t), 0);
    end
    push_start(T_I32); push_data(8'hff); push_data(8'hff); push_data(8'hff);
    push_data(8'hff); push_data(8'h1f);                 // fifth byte too big
    push_start(T_STRUCT); push_data(8'h05); push_data(8'h00); push_data(8'h00);
    push_data(8'h00);                                   // zero long delta
    push_start(T_STRUCT); push_data(8'hf3); push_data(8'h00);
    push_data(8'h80); push_data(8'hff); push_data(8'h03); // one i8 field, then struct end
    push_start(T_LIST); push_data(8'h02);               // empty list of bad type
    for (int k = 0; k < 9; k++) push_start(T_LIST);
    push_start(T_LIST);
    for (int k = 0; k < 8; k++) push_data(8'h19);       // too deep
    push_start(T_BIN); push_data(8'h05); push_data(8'hAA);
    push_word(KIND_END, 4'd0, 8'd0);
    push_word(KIND_DATA, 4'd0, 8'hff); push_word(KIND_RSVD, 4'hf, 8'hff);
    push_start(T_I64); push_start(T_I8); push_data(8'h00); // restart while busy

    // Long receiver hold-off while the sender keeps offering.
    hold_off = 300;
    for (int k = 0; k < 40; k++) begin
      push_start(T_I8);
      push_data(8'($urandom));
    end

    // Random: mostly well-formed values, some noise and broken streams.
    while (word_kind.size() < 1000) begin
      case ($urandom_range(0, 9))
        0: push_word(2'($urandom), 4'($urandom), 8'($urandom));
        1: begin
          push_start(4'($urandom));
          repeat ($urandom_range(0, 6)) push_data(8'($urandom));
          if ($urandom & 1) push_word(KIND_END, 4'($urandom), 8'($urandom));
        end
        default: begin
          tt = ($urandom_range(0, 1)) ? (($urandom & 1) ? T_LIST : T_STRUCT)
               : 4'($urandom_range(3, 8));
          push_start(tt);
          push_value(tt, 0);
        end
      endcase
    end
    stim_done = 1;

    wait (word_kind.size() == 0);
    wait (!in_valid);
    waited = 0;
    while (sb.pending_q.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
